/* rtl/tpa_pkg.sv */
// ----------------------------------------------------------------------------
// tpa_pkg - triangle primitive assembler shared definitions
// Primitive mode codes, register map and default widths.
// ----------------------------------------------------------------------------
package tpa_pkg;

	// Default vertex index width
	localparam int unsigned INDEX_BITS_DEF = 20;

	// Width of the vertex base register
	localparam int unsigned BASE_BITS = 20;

	// Width of the primitive mode register
	localparam int unsigned MODE_BITS = 3;

	// Configuration bus
	localparam int unsigned APB_ADDR_BITS = 3;
	localparam int unsigned APB_DATA_BITS = 32;

	// Register select, taken from the word address bit
	localparam logic REG_PRIM_MODE   = 1'b0;
	localparam logic REG_VERTEX_BASE = 1'b1;

	// Primitive modes; codes above MODE_LINES are discarded like lines/points
	typedef enum logic [MODE_BITS-1:0] {
		MODE_STRIP   = 3'd0,
		MODE_FAN     = 3'd1,
		MODE_POLYGON = 3'd2,
		MODE_TRIS    = 3'd3,
		MODE_QUADS   = 3'd4,
		MODE_LINES   = 3'd5
	} prim_mode_t;

endpackage

/* rtl/triangle_primitive_assembler.sv */
// ----------------------------------------------------------------------------
// triangle_primitive_assembler - vertex stream to triangle index triples
// Counts incoming vertices and emits corner index triples for strips, fans,
// convex polygons, separate triangles and quads.
// ----------------------------------------------------------------------------
// Each triangle is registered in the result queue before it appears on the
// master side. One vertex is accepted per cycle while the queue is not full;
// a quad's two triangles leave one after the other. Accept rate is set by the
// two-entry result queue, which drains one triangle per cycle while m_tready
// is high. Reset clears counters, queue and registers (mode strip, base zero).
module triangle_primitive_assembler #(
	parameter int unsigned INDEX_BITS = tpa_pkg::INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side: tdata[0] prim_end
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,
	// master side: tdata corner_a, corner_b, corner_c (low to high); tlast last_of_run
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((3*INDEX_BITS+7)/8)*8-1:0] m_tdata,
	output logic                              m_tlast,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tpa_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [tpa_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [tpa_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready
);
	import tpa_pkg::*;

	localparam int unsigned IB      = INDEX_BITS;
	localparam int unsigned TRI_W   = 3 * IB;
	localparam int unsigned TDATA_W = ((3 * IB + 7) / 8) * 8;

	// Configuration registers
	logic [MODE_BITS-1:0] mode_q;
	logic [BASE_BITS-1:0] base_q;

	// Assembly state
	logic [IB-1:0] cnt_q;
	logic [IB-1:0] start_q;
	logic [IB-1:0] pos_q;

	// Two-entry result queue, each entry holds the triangles of one vertex
	logic [TRI_W-1:0] tri0_q [2];
	logic [TRI_W-1:0] tri1_q [2];
	logic             two_q  [2];
	logic [1:0]       qcnt_q;
	logic             sub_q;

	logic             cfg_wr;
	logic             in_acc;
	logic             out_acc;
	logic             pop;
	logic             push;
	logic             discard;
	logic             end_flag;
	logic [IB-1:0]    base_x;
	logic [IB-1:0]    j0, j1, j2, j3, js;
	logic [IB-1:0]    cnt_nxt;
	logic [IB-1:0]    pos_inc;
	logic [IB-1:0]    pos_nxt;
	logic             restart;
	logic [1:0]       n_tri;
	logic [TRI_W-1:0] new_tri0;
	logic [TRI_W-1:0] new_tri1;
	logic [TRI_W-1:0] head_tri;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_VERTEX_BASE) begin
			prdata[BASE_BITS-1:0] = base_q;
		end else begin
			prdata[MODE_BITS-1:0] = mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STRIP;
			base_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_VERTEX_BASE) begin
				base_q <= pwdata[BASE_BITS-1:0];
			end else begin
				mode_q <= pwdata[MODE_BITS-1:0];
			end
		end
	end

	// Handshakes
	assign s_tready = (qcnt_q != 2'd2);
	assign in_acc   = s_tvalid & s_tready;
	assign m_tvalid = (qcnt_q != 2'd0);
	assign out_acc  = m_tvalid & m_tready;
	assign pop      = out_acc & (~two_q[0] | sub_q);
	assign end_flag = s_tdata[0];

	// Corner indices relative to the current vertex
	assign base_x  = IB'(base_q);
	assign j0      = base_x + cnt_q;
	assign j1      = base_x + cnt_q - IB'(1);
	assign j2      = base_x + cnt_q - IB'(2);
	assign j3      = base_x + cnt_q - IB'(3);
	assign js      = base_x + start_q;
	assign cnt_nxt = cnt_q + IB'(1);
	assign pos_inc = (pos_q == {IB{1'b1}}) ? (pos_q - IB'(1)) : (pos_q + IB'(1));

	// Triangle selection per mode
	always_comb begin
		discard  = 1'b0;
		n_tri    = 2'd0;
		new_tri0 = {j0, j1, j2};
		new_tri1 = {j0, j1, j2};
		pos_nxt  = pos_inc;
		restart  = 1'b0;
		unique case (mode_q)
			MODE_STRIP: begin
				if (pos_q >= IB'(2)) begin
					n_tri = 2'd1;
					new_tri0 = pos_q[0] ? {j1, j0, j2} : {j0, j1, j2};
				end
				restart = end_flag;
			end
			MODE_FAN: begin
				if (pos_q >= IB'(2)) begin
					n_tri = 2'd1;
					new_tri0 = {j1, j0, js};
				end
				restart = end_flag;
			end
			MODE_POLYGON: begin
				if (pos_q >= IB'(2)) begin
					n_tri = 2'd1;
					new_tri0 = {j0, j1, js};
				end
				restart = end_flag;
			end
			MODE_TRIS: begin
				if (pos_q >= IB'(2)) begin
					n_tri = 2'd1;
					restart = 1'b1;
				end
			end
			MODE_QUADS: begin
				if (pos_q >= IB'(3)) begin
					n_tri = 2'd2;
					new_tri0 = {j0, j2, j3};
					restart = 1'b1;
				end
			end
			default: begin
				discard = 1'b1;
			end
		endcase
		if (restart) begin
			pos_nxt = '0;
		end
	end

	assign push = in_acc & ~discard & (n_tri != 2'd0);

	// Vertex counter and primitive tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (in_acc && !discard) begin
			cnt_q <= cnt_nxt;
			pos_q <= pos_nxt;
			if (pos_nxt == '0) begin
				start_q <= cnt_nxt;
			end
		end
	end

	// Result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= 2'd0;
			sub_q  <= 1'b0;
		end else begin
			qcnt_q <= qcnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) begin
				sub_q <= 1'b0;
			end else if (out_acc) begin
				sub_q <= 1'b1;
			end
		end
	end

	// Result queue payload
	always_ff @(posedge clk) begin
		if (pop) begin
			tri0_q[0] <= tri0_q[1];
			tri1_q[0] <= tri1_q[1];
			two_q[0]  <= two_q[1];
		end
		if (push) begin
			if (qcnt_q == 2'd0 || (qcnt_q == 2'd1 && pop)) begin
				tri0_q[0] <= new_tri0;
				tri1_q[0] <= new_tri1;
				two_q[0]  <= n_tri[1];
			end else begin
				tri0_q[1] <= new_tri0;
				tri1_q[1] <= new_tri1;
				two_q[1]  <= n_tri[1];
			end
		end
	end

	// Output select: second triangle of a quad after the first
	assign head_tri = sub_q ? tri1_q[0] : tri0_q[0];
	assign m_tdata  = TDATA_W'(head_tri);
	assign m_tlast  = ~two_q[0] | sub_q;

endmodule
